// ===== rtl/fpv_pkg.sv =====
// shared types, constants and helpers for the flash program-verify classifier
`timescale 1ns / 1ps
package fpv_pkg;

  localparam int CHUNK_BYTES  = 32;
  localparam int LENGTH_WIDTH = 24;

  localparam int IDX_W     = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
  localparam int POS_W     = $clog2(CHUNK_BYTES + 1);
  localparam int RUN_W     = LENGTH_WIDTH + 1;
  localparam int ADDR_W    = 32;
  localparam int BCOUNT_W  = 25;
  localparam int BITS_W    = 9;
  localparam int BYTE_W    = 8;
  localparam int CMP_W     = (BCOUNT_W > RUN_W) ? BCOUNT_W : RUN_W;
  localparam int OUT_DATA_W = 56;

  typedef enum logic [1:0] {
    CMD_COMPARE = 2'd0,
    CMD_REREAD  = 2'd1,
    CMD_FAIL    = 2'd2,
    CMD_START   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_READ_ERR = 2'd1,
    ST_MISMATCH = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_READ   = 2'd1,
    PH_REREAD = 2'd2
  } phase_t;

  typedef enum logic {
    REG_START_ADDR = 1'b0,
    REG_BYTE_COUNT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] obs;
    logic [BYTE_W-1:0] exp;
  } store_wr_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] mismatch_address;
    logic [BITS_W-1:0] stuck_one_bits;
    logic [BITS_W-1:0] stuck_zero_bits;
    logic              reread_ok;
    logic              stable;
    logic              reread_good;
  } result_t;

  function automatic logic [3:0] pop8(input logic [BYTE_W-1:0] v);
    logic [3:0] n;
    n = '0;
    for (int b = 0; b < BYTE_W; b++) begin
      n = n + 4'(v[b]);
    end
    return n;
  endfunction

endpackage

// ===== rtl/flash_program_verify_classifier.sv =====
// top level: flash program-verify classifier with register port and item streams
// latency: a result is presented on out_tvalid the cycle after the item that causes it
// throughput: one item per cycle while in_tready is high; compare, reread and bookkeeping finish in a single pass
// a two-entry result buffer keeps input flowing while a result waits; in_tready drops only
// when both entries are full
// reset (rst_n low, synchronous): run idle, counters and buffer cleared, registers zero
`timescale 1ns / 1ps
module flash_program_verify_classifier
  import fpv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,  // observed_byte, expected_byte
  input  logic [1:0]            in_tuser,  // command
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // mismatch_address, stuck_one_bits, stuck_zero_bits, reread_ok, stable,
  // reread_good
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]            out_tuser  // status
);

  logic [ADDR_W-1:0]   start_addr_r;
  logic [BCOUNT_W-1:0] byte_count_r;
  logic                cfg_wr;
  reg_idx_t            reg_sel;
  logic                item_acc;
  store_wr_t           store_wr;
  logic [IDX_W-1:0]    rd_idx;
  logic [BYTE_W-1:0]   rd_obs;
  logic [BYTE_W-1:0]   rd_exp;
  logic                res_valid;
  result_t             res;
  result_t             head;
  phase_t              phase;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_sel = reg_idx_t'(paddr[2]);

  always_comb begin
    unique case (reg_sel)
      REG_START_ADDR: prdata = start_addr_r;
      REG_BYTE_COUNT: prdata = 32'(byte_count_r);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_addr_r <= '0;
      byte_count_r <= '0;
    end else if (cfg_wr) begin
      if (reg_sel == REG_START_ADDR) begin
        start_addr_r <= pwdata;
      end else begin
        byte_count_r <= pwdata[BCOUNT_W-1:0];
      end
    end
  end

  assign item_acc = in_tvalid & in_tready;

  fpv_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_acc),
    .cmd           (cmd_t'(in_tuser)),
    .obs           (in_tdata[7:0]),
    .exp           (in_tdata[15:8]),
    .start_address (start_addr_r),
    .byte_count    (byte_count_r),
    .rd_obs        (rd_obs),
    .rd_exp        (rd_exp),
    .store_wr      (store_wr),
    .rd_idx        (rd_idx),
    .res_valid     (res_valid),
    .res           (res),
    .phase         (phase)
  );

  fpv_chunk_store u_store (
    .clk    (clk),
    .wr     (store_wr),
    .rd_idx (rd_idx),
    .rd_obs (rd_obs),
    .rd_exp (rd_exp)
  );

  fpv_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .can_accept (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (head)
  );

  assign out_tuser = head.status;
  assign out_tdata = {3'b000, head.reread_good, head.stable, head.reread_ok,
                      head.stuck_zero_bits, head.stuck_one_bits, head.mismatch_address};

  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (head.status != ST_MISMATCH) |-> out_tdata == '0)
    else $error("non-mismatch result carries payload");

  a_flags_need_reread: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (head.stable || head.reread_good) |-> head.reread_ok)
    else $error("reread flag set without completed reread");

  a_no_idle_to_reread: assert property (@(posedge clk) disable iff (!rst_n)
    phase == PH_IDLE |=> phase != PH_REREAD)
    else $error("reread entered from idle");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty result buffer");

endmodule

// ===== rtl/fpv_chunk_store.sv =====
// per-chunk store of first-read and expected bytes
`timescale 1ns / 1ps
module fpv_chunk_store
  import fpv_pkg::*;
(
  input  logic              clk,
  input  store_wr_t         wr,
  input  logic [IDX_W-1:0]  rd_idx,
  output logic [BYTE_W-1:0] rd_obs,
  output logic [BYTE_W-1:0] rd_exp
);

  logic [BYTE_W-1:0] obs_mem [CHUNK_BYTES];
  logic [BYTE_W-1:0] exp_mem [CHUNK_BYTES];
  logic [BYTE_W-1:0] rd_obs_r;
  logic [BYTE_W-1:0] rd_exp_r;
  logic              fwd;

  assign fwd = wr.we && (wr.idx == rd_idx);

  always_ff @(posedge clk) begin
    if (wr.we) begin
      obs_mem[wr.idx] <= wr.obs;
      exp_mem[wr.idx] <= wr.exp;
    end
  end

  // registered read; a write to the same entry passes straight through
  always_ff @(posedge clk) begin
    rd_obs_r <= fwd ? wr.obs : obs_mem[rd_idx];
    rd_exp_r <= fwd ? wr.exp : exp_mem[rd_idx];
  end

  assign rd_obs = rd_obs_r;
  assign rd_exp = rd_exp_r;

endmodule

// ===== rtl/fpv_ctrl.sv =====
// run and chunk sequencing, compare, bit counting and result build
`timescale 1ns / 1ps
module fpv_ctrl
  import fpv_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  cmd_t                cmd,
  input  logic [BYTE_W-1:0]   obs,
  input  logic [BYTE_W-1:0]   exp,
  input  logic [ADDR_W-1:0]   start_address,
  input  logic [BCOUNT_W-1:0] byte_count,
  input  logic [BYTE_W-1:0]   rd_obs,
  input  logic [BYTE_W-1:0]   rd_exp,
  output store_wr_t           store_wr,
  output logic [IDX_W-1:0]    rd_idx,
  output logic                res_valid,
  output result_t             res,
  output phase_t              phase
);

  phase_t            phase_r, phase_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [RUN_W-1:0]  remain_r, remain_nxt;
  logic [ADDR_W-1:0] chunk_addr_r, chunk_addr_nxt;
  logic              mis_r, mis_nxt;
  logic [IDX_W-1:0]  first_r, first_nxt;
  logic [BITS_W-1:0] miss_r, miss_nxt;
  logic [BITS_W-1:0] extra_r, extra_nxt;
  logic              stable_r, stable_nxt;
  logic              match_r, match_nxt;

  logic [POS_W-1:0]  pos_inc;
  logic [POS_W-1:0]  chunk_len;
  logic              chunk_end;
  logic              lim_hit;
  logic [RUN_W-1:0]  run_len;
  logic              mis_upd;
  logic [RUN_W-1:0]  remain_after;
  logic              stable_upd;
  logic              match_upd;
  result_t           full_res;

  assign pos_inc   = POS_W'(pos_r) + POS_W'(1);
  assign chunk_len = (remain_r >= RUN_W'(CHUNK_BYTES)) ? POS_W'(CHUNK_BYTES)
                                                       : POS_W'(remain_r);
  assign chunk_end = (pos_inc >= chunk_len);
  assign lim_hit   = CMP_W'(byte_count) > (CMP_W'(1) << LENGTH_WIDTH);
  assign run_len   = lim_hit ? (RUN_W'(1) << LENGTH_WIDTH) : RUN_W'(byte_count);
  assign mis_upd   = mis_r | (obs != exp);
  assign remain_after = remain_r - RUN_W'(chunk_len);
  assign stable_upd = stable_r & (obs == rd_obs);
  assign match_upd  = match_r & (obs == rd_exp);
  // store read data is registered, so it is addressed with the next position
  assign rd_idx     = pos_nxt;
  assign phase      = phase_r;

  always_comb begin
    full_res                   = '0;
    full_res.status            = ST_MISMATCH;
    full_res.mismatch_address  = chunk_addr_r + ADDR_W'(first_r);
    full_res.stuck_one_bits    = miss_r;
    full_res.stuck_zero_bits   = extra_r;
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (item_valid) begin
      unique case (cmd)
        CMD_START: begin
          phase_nxt = (run_len == '0) ? PH_IDLE : PH_READ;
        end
        CMD_FAIL: begin
          phase_nxt = PH_IDLE;
        end
        CMD_COMPARE: begin
          if (phase_r == PH_READ && chunk_end) begin
            if (mis_upd) begin
              phase_nxt = PH_REREAD;
            end else if (remain_after == '0) begin
              phase_nxt = PH_IDLE;
            end
          end
        end
        CMD_REREAD: begin
          if (phase_r == PH_REREAD && chunk_end) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    pos_nxt        = pos_r;
    remain_nxt     = remain_r;
    chunk_addr_nxt = chunk_addr_r;
    mis_nxt        = mis_r;
    first_nxt      = first_r;
    miss_nxt       = miss_r;
    extra_nxt      = extra_r;
    stable_nxt     = stable_r;
    match_nxt      = match_r;
    store_wr       = '0;
    res_valid      = 1'b0;
    res            = '0;
    if (item_valid) begin
      case (cmd)
        CMD_START: begin
          chunk_addr_nxt = start_address;
          remain_nxt     = run_len;
          pos_nxt        = '0;
          mis_nxt        = 1'b0;
          first_nxt      = '0;
          miss_nxt       = '0;
          extra_nxt      = '0;
          stable_nxt     = 1'b1;
          match_nxt      = 1'b1;
          if (run_len == '0) begin
            res_valid  = 1'b1;
            res.status = ST_OK;
          end
        end
        CMD_FAIL: begin
          if (phase_r == PH_READ) begin
            res_valid  = 1'b1;
            res.status = ST_READ_ERR;
          end else if (phase_r == PH_REREAD) begin
            res_valid = 1'b1;
            res       = full_res;
          end
        end
        CMD_COMPARE: begin
          if (phase_r == PH_READ) begin
            store_wr.we  = 1'b1;
            store_wr.idx = pos_r;
            store_wr.obs = obs;
            store_wr.exp = exp;
            mis_nxt      = mis_upd;
            if (!mis_r && (obs != exp)) begin
              first_nxt = pos_r;
            end
            miss_nxt  = miss_r + BITS_W'(pop8(obs & ~exp));
            extra_nxt = extra_r + BITS_W'(pop8(exp & ~obs));
            pos_nxt   = IDX_W'(pos_inc);
            if (chunk_end) begin
              pos_nxt    = '0;
              stable_nxt = 1'b1;
              match_nxt  = 1'b1;
              if (!mis_upd) begin
                chunk_addr_nxt = chunk_addr_r + ADDR_W'(chunk_len);
                remain_nxt     = remain_after;
                mis_nxt        = 1'b0;
                first_nxt      = '0;
                miss_nxt       = '0;
                extra_nxt      = '0;
                if (remain_after == '0) begin
                  res_valid  = 1'b1;
                  res.status = ST_OK;
                end
              end
            end
          end
        end
        default: begin
          if (phase_r == PH_REREAD) begin
            stable_nxt = stable_upd;
            match_nxt  = match_upd;
            pos_nxt    = IDX_W'(pos_inc);
            if (chunk_end) begin
              pos_nxt   = '0;
              res_valid = 1'b1;
              res       = full_res;
              res.reread_ok   = 1'b1;
              res.stable      = stable_upd;
              res.reread_good = match_upd;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      pos_r        <= '0;
      remain_r     <= '0;
      chunk_addr_r <= '0;
      mis_r        <= 1'b0;
      first_r      <= '0;
      miss_r       <= '0;
      extra_r      <= '0;
      stable_r     <= 1'b1;
      match_r      <= 1'b1;
    end else begin
      phase_r      <= phase_nxt;
      pos_r        <= pos_nxt;
      remain_r     <= remain_nxt;
      chunk_addr_r <= chunk_addr_nxt;
      mis_r        <= mis_nxt;
      first_r      <= first_nxt;
      miss_r       <= miss_nxt;
      extra_r      <= extra_nxt;
      stable_r     <= stable_nxt;
      match_r      <= match_nxt;
    end
  end

endmodule

// ===== rtl/fpv_out_buf.sv =====
// two-entry result buffer between the classifier and the result channel
`timescale 1ns / 1ps
module fpv_out_buf
  import fpv_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    can_accept,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t    slot0_r;
  result_t    slot1_r;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign can_accept = (count_r != 2'd2);
  assign out_valid  = (count_r != 2'd0);
  assign out_data   = rd_ptr_r ? slot1_r : slot0_r;
  assign pop        = out_valid & out_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (wr_ptr_r) begin
        slot1_r <= push_data;
      end else begin
        slot0_r <= push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== verif/fpv_result_checker.sv =====
// result checker for the flash program-verify classifier: predicts and compares results
`timescale 1ns / 1ps
module fpv_result_checker
  import fpv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [15:0]           in_tdata,
  input  logic [1:0]            in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [1:0]            out_tuser,
  output int                    fail_count,
  output int                    pending
);

  localparam logic [BCOUNT_W-1:0] RUN_LIMIT = BCOUNT_W'(1) << LENGTH_WIDTH;

  // register shadows
  logic [ADDR_W-1:0]   reg_start;
  logic [BCOUNT_W-1:0] reg_count;

  // run and chunk state
  phase_t              cur_phase;
  logic [ADDR_W-1:0]   run_base;
  logic [BCOUNT_W-1:0] run_len;
  logic [BCOUNT_W-1:0] done_bytes;
  int                  pos;
  logic [7:0]          first_read [CHUNK_BYTES];
  logic [7:0]          image [CHUNK_BYTES];
  bit                  diff_seen;
  int                  first_bad;
  logic [BITS_W-1:0]   ones_where_zero;
  logic [BITS_W-1:0]   zeros_where_one;
  bit                  same_as_first;
  bit                  same_as_image;

  result_t expected_results [$];
  result_t seen;
  result_t want;
  bit      made;
  int      fails;

  function automatic void clear_chunk();
    pos = 0;
    diff_seen = 1'b0;
    first_bad = 0;
    ones_where_zero = '0;
    zeros_where_one = '0;
    same_as_first = 1'b1;
    same_as_image = 1'b1;
  endfunction

  function automatic result_t mismatch_result(input bit rok);
    result_t res;
    res = '0;
    res.status = ST_MISMATCH;
    res.mismatch_address = run_base + ADDR_W'(done_bytes) + ADDR_W'(first_bad);
    res.stuck_one_bits = ones_where_zero;
    res.stuck_zero_bits = zeros_where_one;
    res.reread_ok = rok;
    res.stable = rok && same_as_first;
    res.reread_good = rok && same_as_image;
    return res;
  endfunction

  task automatic predict_item(input cmd_t cmd, input logic [7:0] obs, input logic [7:0] img,
                              output bit produced, output result_t res);
    int unsigned rem;
    int unsigned span;
    int p;
    produced = 1'b0;
    res = '0;
    rem = 32'(run_len - done_bytes);
    span = (rem > CHUNK_BYTES) ? CHUNK_BYTES : rem;
    case (cmd)
      CMD_START: begin
        run_base = reg_start;
        run_len = (reg_count > RUN_LIMIT) ? RUN_LIMIT : reg_count;
        done_bytes = '0;
        clear_chunk();
        if (run_len == 0) begin
          cur_phase = PH_IDLE;
          produced = 1'b1;
          res.status = ST_OK;
        end else begin
          cur_phase = PH_READ;
        end
      end
      CMD_FAIL: begin
        if (cur_phase == PH_READ) begin
          cur_phase = PH_IDLE;
          produced = 1'b1;
          res.status = ST_READ_ERR;
        end else if (cur_phase == PH_REREAD) begin
          cur_phase = PH_IDLE;
          produced = 1'b1;
          res = mismatch_result(1'b0);
        end
      end
      CMD_COMPARE: begin
        if (cur_phase == PH_READ) begin
          p = pos;
          first_read[p] = obs;
          image[p] = img;
          if (obs != img && !diff_seen) begin
            diff_seen = 1'b1;
            first_bad = p;
          end
          ones_where_zero = ones_where_zero + BITS_W'($countones(obs & ~img));
          zeros_where_one = zeros_where_one + BITS_W'($countones(img & ~obs));
          pos = p + 1;
          if (pos >= span) begin
            if (diff_seen) begin
              cur_phase = PH_REREAD;
              pos = 0;
              same_as_first = 1'b1;
              same_as_image = 1'b1;
            end else begin
              done_bytes = done_bytes + BCOUNT_W'(span);
              clear_chunk();
              if (done_bytes >= run_len) begin
                cur_phase = PH_IDLE;
                produced = 1'b1;
                res.status = ST_OK;
              end
            end
          end
        end
      end
      default: begin
        if (cur_phase == PH_REREAD) begin
          p = pos;
          if (obs != first_read[p]) same_as_first = 1'b0;
          if (obs != image[p]) same_as_image = 1'b0;
          pos = p + 1;
          if (pos >= span) begin
            cur_phase = PH_IDLE;
            produced = 1'b1;
            res = mismatch_result(1'b1);
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reg_start = '0;
      reg_count = '0;
      cur_phase = PH_IDLE;
      run_base = '0;
      run_len = '0;
      done_bytes = '0;
      clear_chunk();
      expected_results.delete();
      fails = 0;
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_START_ADDR, 2'b00}) begin
          reg_start = pwdata;
        end else if (paddr == {REG_BYTE_COUNT, 2'b00}) begin
          reg_count = pwdata[BCOUNT_W-1:0];
        end
      end
      if (out_tvalid && out_tready) begin
        seen.status = status_t'(out_tuser);
        seen.mismatch_address = out_tdata[31:0];
        seen.stuck_one_bits = out_tdata[40:32];
        seen.stuck_zero_bits = out_tdata[49:41];
        seen.reread_ok = out_tdata[50];
        seen.stable = out_tdata[51];
        seen.reread_good = out_tdata[52];
        if (expected_results.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("unexpected result: status %0d address %h", out_tuser, out_tdata[31:0]);
          end
        end else begin
          want = expected_results.pop_front();
          if (seen !== want || out_tdata[55:53] !== 3'b000) begin
            fails++;
            if (fails <= 10) begin
              $display("result mismatch at %0t: status exp %0d got %0d, address exp %h got %h",
                       $realtime, want.status, out_tuser, want.mismatch_address,
                       seen.mismatch_address);
              $display("  missing exp %0d got %0d, extra exp %0d got %0d, pad %b",
                       want.stuck_one_bits, seen.stuck_one_bits,
                       want.stuck_zero_bits, seen.stuck_zero_bits, out_tdata[55:53]);
              $display("  ok/stable/match exp %b%b%b got %b%b%b", want.reread_ok,
                       want.stable, want.reread_good, seen.reread_ok,
                       seen.stable, seen.reread_good);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_item(cmd_t'(in_tuser), in_tdata[7:0], in_tdata[15:8], made, want);
        if (made) expected_results.push_back(want);
      end
      fail_count <= fails;
      pending <= expected_results.size();
    end
  end

endmodule

// ===== verif/flash_program_verify_classifier_test.sv =====
// testbench top for the flash program-verify classifier: stimulus, flow control and verdict
`timescale 1ns / 1ps
module flash_program_verify_classifier_test;
  import fpv_pkg::*;

  localparam int RUN_LIMIT = 1 << LENGTH_WIDTH;
  localparam int HOLD_CYCLES = 150;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [2:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = '0;   // observed_byte, expected_byte
  logic [1:0]            in_tuser = '0;   // command
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // mismatch_address, stuck_one_bits, stuck_zero_bits, reread_ok, stable,
  // reread_good
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;       // status
  int                    fail_count;
  int                    pending;

  int                  items_sent = 0;
  int                  gap_pct = 36;
  int                  stall_pct = 36;
  int                  hold_requests = 0;
  int                  holds_served = 0;
  logic [BCOUNT_W-1:0] count_reg = '0;

  flash_program_verify_classifier dut (.*);

  fpv_result_checker result_check (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic send_item(input cmd_t cmd, input logic [7:0] obs, input logic [7:0] img);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {img, obs};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic send_ignored(input cmd_t cmd);
    send_item(cmd, 8'($urandom), 8'($urandom));
    items_sent--;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_BYTE_COUNT) count_reg = value[BCOUNT_W-1:0];
  endtask

  // one verify run; stops at the first bad chunk, or early on a read failure
  task automatic verify_run(input int unsigned len, input int unsigned chunk_cap);
    logic [7:0]  first_pass [CHUNK_BYTES];
    logic [7:0]  image [CHUNK_BYTES];
    logic [7:0]  b;
    int unsigned done;
    int unsigned clen;
    int unsigned chunks;
    int          flavour;
    int          i;
    bit          restarted;
    bit          again;
    bit          bad;
    if ($urandom_range(0, 9) == 0) send_ignored(cmd_t'($urandom_range(0, 2)));
    send_item(CMD_START, 8'($urandom), 8'($urandom));
    restarted = 1'b0;
    done = 0;
    chunks = 0;
    while (done < len) begin
      if (chunks == chunk_cap) begin
        send_item(CMD_FAIL, 8'($urandom), 8'($urandom));
        return;
      end
      clen = (len - done > CHUNK_BYTES) ? CHUNK_BYTES : len - done;
      flavour = $urandom_range(0, 99);
      bad = 1'b0;
      again = 1'b0;
      for (i = 0; i < clen; i++) begin
        if ($urandom_range(0, 99) < 2) send_ignored(CMD_REREAD);
        if ($urandom_range(0, 199) == 0) begin
          send_item(CMD_FAIL, 8'($urandom), 8'($urandom));
          return;
        end
        if (!restarted && $urandom_range(0, 299) == 0) begin
          restarted = 1'b1;
          again = 1'b1;
          send_item(CMD_START, 8'($urandom), 8'($urandom));
          break;
        end
        if (flavour < 6) begin
          image[i] = 8'hFF;
          first_pass[i] = 8'h00;
        end else if (flavour < 12) begin
          image[i] = 8'h00;
          first_pass[i] = 8'hFF;
        end else begin
          image[i] = 8'($urandom);
          first_pass[i] = image[i];
          if (flavour < 40 && ($urandom_range(0, 3) == 0 || (i == clen - 1 && !bad))) begin
            first_pass[i] = image[i] ^ 8'($urandom_range(1, 255));
          end
        end
        if (first_pass[i] != image[i]) bad = 1'b1;
        send_item(CMD_COMPARE, first_pass[i], image[i]);
      end
      if (again) begin
        done = 0;
        chunks = 0;
        continue;
      end
      chunks++;
      if (!bad) begin
        done += clen;
        continue;
      end
      flavour = $urandom_range(0, 3);
      for (i = 0; i < clen; i++) begin
        if ($urandom_range(0, 99) < 2) send_ignored(CMD_COMPARE);
        if ($urandom_range(0, 99) == 0) begin
          send_item(CMD_FAIL, 8'($urandom), 8'($urandom));
          return;
        end
        case (flavour)
          0:       b = first_pass[i];
          1:       b = image[i];
          2:       b = ($urandom_range(0, 7) == 0) ? 8'($urandom) : first_pass[i];
          default: b = 8'($urandom);
        endcase
        send_item(CMD_REREAD, b, 8'($urandom));
      end
      return;
    end
  endtask

  initial begin
    int unsigned len;
    int unsigned cap;
    logic [31:0] value;
    int          r;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle block ignores all but a start; empty run with the reset count
    send_ignored(CMD_COMPARE);
    send_ignored(CMD_REREAD);
    send_ignored(CMD_FAIL);
    send_item(CMD_START, 8'h00, 8'h00);
    settle();
    cfg_write(REG_START_ADDR, 32'hFFFF_FFFF);
    cfg_write(REG_BYTE_COUNT, 32'd3);
    // full reread, stable but still wrong
    send_item(CMD_START, 8'hFF, 8'hFF);
    send_item(CMD_COMPARE, 8'h00, 8'hFF);
    send_item(CMD_COMPARE, 8'hFF, 8'h00);
    send_item(CMD_COMPARE, 8'hA5, 8'hA5);
    send_ignored(CMD_COMPARE);
    send_item(CMD_REREAD, 8'h00, 8'h00);
    send_item(CMD_REREAD, 8'hFF, 8'h00);
    send_item(CMD_REREAD, 8'hA5, 8'h00);
    // failure during reread, address wraps past the top
    send_item(CMD_START, 8'h00, 8'h00);
    send_item(CMD_COMPARE, 8'h12, 8'h12);
    send_item(CMD_COMPARE, 8'h34, 8'h35);
    send_item(CMD_COMPARE, 8'h56, 8'h56);
    send_item(CMD_REREAD, 8'h12, 8'h00);
    send_item(CMD_FAIL, 8'h00, 8'h00);
    // read error, then restart mid-run ending clean
    send_item(CMD_START, 8'h00, 8'h00);
    send_item(CMD_COMPARE, 8'h77, 8'h77);
    send_item(CMD_FAIL, 8'hFF, 8'hFF);
    send_item(CMD_START, 8'h00, 8'h00);
    send_item(CMD_COMPARE, 8'h01, 8'h01);
    send_ignored(CMD_REREAD);
    send_item(CMD_START, 8'h00, 8'h00);
    send_item(CMD_COMPARE, 8'h80, 8'h80);
    send_item(CMD_COMPARE, 8'h7F, 8'h7F);
    send_item(CMD_COMPARE, 8'h00, 8'h00);

    // back-pressure: empty runs pile up results while the receiver holds off
    settle();
    cfg_write(REG_BYTE_COUNT, 32'd0);
    gap_pct = 0;
    hold_requests++;
    repeat (12) send_item(CMD_START, 8'($urandom), 8'($urandom));
    settle();

    while (items_sent < 750) begin
      gap_pct = (items_sent >= 300 && items_sent < 420) ? 0 : 36;
      stall_pct = gap_pct;
      if ($urandom_range(0, 99) < 35) begin
        settle();
        if ($urandom_range(0, 1) == 1) begin
          r = $urandom_range(0, 9);
          if (r == 0) value = 32'hFFFF_FFFF;
          else if (r == 1) value = 32'h0;
          else if (r == 2) value = 32'hFFFF_FFE0 + $urandom_range(0, 31);
          else value = $urandom;
          cfg_write(REG_START_ADDR, value);
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
          value = 32'd0;
        end else if (r < 10) begin
          case ($urandom_range(0, 3))
            0:       value = 32'hFFFF_FFFF;
            1:       value = RUN_LIMIT;
            2:       value = RUN_LIMIT + 1;
            default: value = RUN_LIMIT - 1;
          endcase
        end else if (r < 20) begin
          value = CHUNK_BYTES * $urandom_range(1, 3);
        end else begin
          value = $urandom_range(1, 80);
        end
        cfg_write(REG_BYTE_COUNT, value);
      end
      len = (count_reg > RUN_LIMIT) ? RUN_LIMIT : count_reg;
      cap = (len > 256) ? $urandom_range(1, 3) : 1 << 20;
      verify_run(len, cap);
      if ($urandom_range(0, 29) == 0) settle();
    end

    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
